>>> rtl/ltw_pkg.sv
// shared types, constants and helpers for the local translation warp core
// no dependencies
`default_nettype none

package ltw_pkg;

  // store geometry
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int BANK_ADDR_W = 14;
  localparam int BANK_DEPTH  = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);

  // pipeline sizes
  localparam int SQ_BITS    = 24;
  localparam int SQ_REM_W   = 49;
  localparam int DV_BITS    = 17;
  localparam int DV_REM_W   = 25;
  localparam int FIFO_DEPTH = 4;

  // reciprocal of 50 scaled by 2^32, rounded up
  localparam logic [26:0] DIV50_MUL = 27'd85899346;
  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [8:0]  MAX_DIM   = 9'd256;

  // register indexes
  localparam logic [2:0] REG_IMG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CENTER_X   = 3'd2;
  localparam logic [2:0] REG_CENTER_Y   = 3'd3;
  localparam logic [2:0] REG_TARGET_X   = 3'd4;
  localparam logic [2:0] REG_TARGET_Y   = 3'd5;
  localparam logic [2:0] REG_RADIUS     = 3'd6;
  localparam logic [2:0] REG_STRENGTH   = 3'd7;

  // item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic [8:0] img_width;
    logic [8:0] img_height;
    logic [7:0] center_x;
    logic [7:0] center_y;
    logic [7:0] target_x;
    logic [7:0] target_y;
    logic [6:0] radius;
    logic [7:0] strength;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [23:0] pix;
    logic        in_win;
    logic        near;
  } item_t;

  typedef struct packed {
    item_t       it;
    logic [14:0] d2;
  } front_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  x1;
    logic [7:0]  y1;
    logic [15:0] fx;
    logic [15:0] fy;
    logic        zero;
    logic        in_win;
    logic [23:0] pix;
  } samp_t;

  // image size clipped to the store
  function automatic logic [8:0] clip_dim(input logic [8:0] v);
    clip_dim = (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/local_translation_warp_bilinear_core.sv
// top level of the local translation warp core: configuration registers
// and the front end, queue, warp datapath and sampler; depends on ltw_pkg
`default_nettype none

// Loads (mode 0) write one pixel of the frame store and give no result;
// queries (mode 1) give one warped pixel on out_ch0..2 with in_window,
// flagged by done for a single cycle, which the receiver must take.
// One item is taken every clock cycle while busy is low; each query result
// passes through the 24-stage square root and the 17-stage divide that
// turn distance into the weight. Results keep the order of the items,
// and a query sees every load transferred before it. The user must write
// registers only while no item is in flight; the block does not enforce it.
module local_translation_warp_bilinear_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       mode,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic [7:0] in_ch0,
  input  logic [7:0] in_ch1,
  input  logic [7:0] in_ch2,
  output logic       done,
  output logic [7:0] out_ch0,
  output logic [7:0] out_ch1,
  output logic [7:0] out_ch2,
  output logic       in_window,
  input  logic       wr_en,
  input  logic [2:0] wr_index,
  input  logic [8:0] wr_data
);
  import ltw_pkg::*;

  cfg_t   cfg;
  logic   f_valid, q_valid, w_valid;
  front_t f_item, q_item;
  samp_t  w_samp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.img_width  <= 9'd256;
      cfg.img_height <= 9'd256;
      cfg.center_x   <= 8'd0;
      cfg.center_y   <= 8'd0;
      cfg.target_x   <= 8'd0;
      cfg.target_y   <= 8'd0;
      cfg.radius     <= 7'd15;
      cfg.strength   <= 8'd20;
    end else if (wr_en) begin
      case (wr_index)
        REG_IMG_WIDTH:  cfg.img_width  <= wr_data;
        REG_IMG_HEIGHT: cfg.img_height <= wr_data;
        REG_CENTER_X:   cfg.center_x   <= wr_data[7:0];
        REG_CENTER_Y:   cfg.center_y   <= wr_data[7:0];
        REG_TARGET_X:   cfg.target_x   <= wr_data[7:0];
        REG_TARGET_Y:   cfg.target_y   <= wr_data[7:0];
        REG_RADIUS:     cfg.radius     <= wr_data[6:0];
        REG_STRENGTH:   cfg.strength   <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  ltw_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .start(start), .busy(busy),
    .mode(mode), .x(x), .y(y),
    .in_ch0(in_ch0), .in_ch1(in_ch1), .in_ch2(in_ch2),
    .out_valid(f_valid), .out_item(f_item)
  );

  ltw_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push(f_valid), .din(f_item),
    .out_valid(q_valid), .dout(q_item),
    .almost_full(busy)
  );

  ltw_warp u_warp (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(q_valid), .in_item(q_item),
    .out_valid(w_valid), .out_samp(w_samp)
  );

  ltw_sampler u_sampler (
    .clk(clk), .rst(rst),
    .in_valid(w_valid), .in_samp(w_samp),
    .done(done),
    .out_ch0(out_ch0), .out_ch1(out_ch1), .out_ch2(out_ch2),
    .in_window(in_window)
  );

endmodule

`default_nettype wire

>>> rtl/ltw_front.sv
// front end: accepts items, classifies queries against the warp window
// depends on ltw_pkg
`default_nettype none

module ltw_front (
  input  logic          clk,
  input  logic          rst,
  input  ltw_pkg::cfg_t cfg,
  input  logic          start,
  input  logic          busy,
  input  logic          mode,
  input  logic [7:0]    x,
  input  logic [7:0]    y,
  input  logic [7:0]    in_ch0,
  input  logic [7:0]    in_ch1,
  input  logic [7:0]    in_ch2,
  output logic          out_valid,
  output ltw_pkg::front_t out_item
);
  import ltw_pkg::*;

  logic [8:0]        w, h;
  logic signed [9:0] dx, dy, rs;
  logic signed [19:0] dx2, dy2;
  logic [17:0]       d2_full;
  logic [13:0]       r2;
  logic              win;

  // window classification
  assign w   = clip_dim(cfg.img_width);
  assign h   = clip_dim(cfg.img_height);
  assign dx  = $signed({2'b0, x}) - $signed({2'b0, cfg.center_x});
  assign dy  = $signed({2'b0, y}) - $signed({2'b0, cfg.center_y});
  assign rs  = $signed({3'b0, cfg.radius});
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;
  assign d2_full = dx2[17:0] + dy2[17:0];
  assign r2  = {7'b0, cfg.radius} * {7'b0, cfg.radius};
  assign win = ({1'b0, x} < w) && ({1'b0, y} < h) &&
               (dx >= -rs) && (dx < rs) && (dy >= -rs) && (dy < rs);

  // transfer register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    out_item.it.mode   <= mode;
    out_item.it.x      <= x;
    out_item.it.y      <= y;
    out_item.it.pix    <= {in_ch2, in_ch1, in_ch0};
    out_item.it.in_win <= win && (mode == MODE_QUERY);
    out_item.it.near   <= d2_full <= {4'b0, r2};
    out_item.d2        <= d2_full[14:0];
  end

endmodule

`default_nettype wire

>>> rtl/ltw_fifo.sv
// short queue between front end and warp datapath
// depends on ltw_pkg
`default_nettype none

module ltw_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ltw_pkg::front_t din,
  output logic            out_valid,
  output ltw_pkg::front_t dout,
  output logic            almost_full
);
  import ltw_pkg::*;

  front_t     mem [0:FIFO_DEPTH-1];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       pop;

  // the datapath never stalls, so the head leaves whenever present
  assign out_valid   = count != 3'd0;
  assign pop         = out_valid;
  assign dout        = mem[rd_ptr];
  assign almost_full = count >= 3'(FIFO_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

endmodule

`default_nettype wire

>>> rtl/ltw_warp.sv
// warp datapath: pipelined square root, divide, weight polynomial and
// source coordinate; depends on ltw_pkg
`default_nettype none

module ltw_warp (
  input  logic            clk,
  input  logic            rst,
  input  ltw_pkg::cfg_t   cfg,
  input  logic            in_valid,
  input  ltw_pkg::front_t in_item,
  output logic            out_valid,
  output ltw_pkg::samp_t  out_samp
);
  import ltw_pkg::*;

  // ---------------- square root, one result bit a stage
  logic                sq_v    [0:SQ_BITS];
  logic [SQ_REM_W-1:0] sq_rem  [0:SQ_BITS];
  logic [SQ_BITS-1:0]  sq_root [0:SQ_BITS];
  item_t               sq_it   [0:SQ_BITS];

  assign sq_v[0]    = in_valid;
  assign sq_rem[0]  = {2'b0, in_item.d2, 32'b0};
  assign sq_root[0] = '0;
  assign sq_it[0]   = in_item.it;

  for (genvar j = 0; j < SQ_BITS; j++) begin : g_sqrt
    localparam int B = SQ_BITS - 1 - j;
    logic [SQ_REM_W-1:0] trial;
    assign trial = ({(SQ_REM_W - SQ_BITS)'(0), sq_root[j]} << (B + 1)) +
                   (SQ_REM_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j+1] <= 1'b0;
      end else begin
        sq_v[j+1] <= sq_v[j];
      end
    end

    always_ff @(posedge clk) begin
      sq_it[j+1] <= sq_it[j];
      if (sq_rem[j] >= trial) begin
        sq_rem[j+1]  <= sq_rem[j] - trial;
        sq_root[j+1] <= sq_root[j] | (SQ_BITS'(1) << B);
      end else begin
        sq_rem[j+1]  <= sq_rem[j];
        sq_root[j+1] <= sq_root[j];
      end
    end
  end

  // ---------------- distance over radius, restoring divide
  logic                dv_v   [0:DV_BITS];
  logic [DV_REM_W-1:0] dv_rem [0:DV_BITS];
  logic [DV_BITS-1:0]  dv_q   [0:DV_BITS];
  item_t               dv_it  [0:DV_BITS];

  assign dv_v[0]   = sq_v[SQ_BITS];
  assign dv_rem[0] = {1'b0, sq_root[SQ_BITS]};
  assign dv_q[0]   = '0;
  assign dv_it[0]  = sq_it[SQ_BITS];

  for (genvar j = 0; j < DV_BITS; j++) begin : g_div
    localparam int B = DV_BITS - 1 - j;
    logic [DV_REM_W-1:0] sub;
    assign sub = {(DV_REM_W - 7)'(0), cfg.radius} << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk) begin
      dv_it[j+1] <= dv_it[j];
      if (dv_rem[j] >= sub) begin
        dv_rem[j+1] <= dv_rem[j] - sub;
        dv_q[j+1]   <= dv_q[j] | (DV_BITS'(1) << B);
      end else begin
        dv_rem[j+1] <= dv_rem[j];
        dv_q[j+1]   <= dv_q[j];
      end
    end
  end

  // ---------------- weight polynomial and strength scaling
  logic [6:1]  pv;
  item_t       p_it [1:6];
  logic [16:0] tq, p1_tq, p1_t2, p2_tq, p2_t3, p3_t3, p3_t4, p4_pq;
  logic [24:0] p5_prod;
  logic [18:0] p6_kq;
  logic [33:0] m1, m2, m3;
  logic [18:0] pa, pb, pdiff;
  logic [16:0] pq_c;
  logic [51:0] km;

  assign tq = dv_q[DV_BITS];
  assign m1 = {17'b0, tq} * {17'b0, tq};
  assign m2 = {17'b0, p1_t2} * {17'b0, p1_tq};
  assign m3 = {17'b0, p2_t3} * {17'b0, p2_tq};
  assign pa = {2'b0, p3_t4} + {1'b0, p3_t4, 1'b0} + {2'b0, ONE_Q16};
  assign pb = {p3_t3, 2'b00};
  assign pdiff = pa - pb;
  assign pq_c = (pa <= pb) ? 17'd0 :
                (pdiff > {2'b0, ONE_Q16}) ? ONE_Q16 : pdiff[16:0];
  assign km = {27'b0, p5_prod} * {25'b0, DIV50_MUL};

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      pv <= {pv[5:1], dv_v[DV_BITS]};
    end
  end

  always_ff @(posedge clk) begin
    p_it[1] <= dv_it[DV_BITS];
    for (int i = 2; i <= 6; i++) begin
      p_it[i] <= p_it[i-1];
    end
    p1_tq   <= tq;
    p1_t2   <= m1[32:16];
    p2_tq   <= p1_tq;
    p2_t3   <= m2[32:16];
    p3_t3   <= p2_t3;
    p3_t4   <= m3[32:16];
    p4_pq   <= pq_c;
    p5_prod <= {17'b0, cfg.strength} * {8'b0, p4_pq};
    p6_kq   <= (p_it[5].in_win && p_it[5].near) ? km[50:32] : 19'd0;
  end

  // ---------------- source coordinate
  logic signed [8:0]  dtx, dty;
  logic signed [28:0] prx, pry;
  logic signed [29:0] c1_sx, c1_sy;
  item_t              c1_it;
  logic               c1_v;
  logic [8:0]         wm1, hm1;
  logic               in_range;

  assign dtx = $signed({1'b0, cfg.target_x}) - $signed({1'b0, cfg.center_x});
  assign dty = $signed({1'b0, cfg.target_y}) - $signed({1'b0, cfg.center_y});
  assign prx = $signed({1'b0, p6_kq}) * dtx;
  assign pry = $signed({1'b0, p6_kq}) * dty;
  assign wm1 = clip_dim(cfg.img_width) - 9'd1;
  assign hm1 = clip_dim(cfg.img_height) - 9'd1;
  assign in_range = !c1_sx[29] && !c1_sy[29] &&
                    (c1_sx[28:16] < {4'b0, wm1}) && (c1_sy[28:16] < {4'b0, hm1});

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      c1_v      <= pv[6];
      out_valid <= c1_v;
    end
  end

  always_ff @(posedge clk) begin
    c1_it <= p_it[6];
    c1_sx <= $signed({6'b0, p_it[6].x, 16'b0}) - {prx[28], prx};
    c1_sy <= $signed({6'b0, p_it[6].y, 16'b0}) - {pry[28], pry};

    out_samp.mode   <= c1_it.mode;
    out_samp.in_win <= c1_it.in_win;
    out_samp.pix    <= c1_it.pix;
    if (c1_it.in_win) begin
      out_samp.x1   <= c1_sx[23:16];
      out_samp.y1   <= c1_sy[23:16];
      out_samp.fx   <= c1_sx[15:0];
      out_samp.fy   <= c1_sy[15:0];
      out_samp.zero <= !in_range;
    end else begin
      // loads and pass-through queries address the pixel itself
      out_samp.x1   <= c1_it.x;
      out_samp.y1   <= c1_it.y;
      out_samp.fx   <= 16'd0;
      out_samp.fy   <= 16'd0;
      out_samp.zero <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ltw_sampler.sv
// frame store in four parity banks and bilinear blend
// depends on ltw_pkg
`default_nettype none

module ltw_sampler (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  ltw_pkg::samp_t in_samp,
  output logic           done,
  output logic [7:0]     out_ch0,
  output logic [7:0]     out_ch1,
  output logic [7:0]     out_ch2,
  output logic           in_window
);
  import ltw_pkg::*;

  logic [23:0] rd [0:3];
  logic        a_v, b_v;
  samp_t       a_s, b_s;
  logic [33:0] a_w [0:3];
  logic [16:0] wx0, wx1, wy0, wy1;
  logic [23:0] p [0:3];
  logic [41:0] b_pr [0:2][0:3];

  // one bank per column and row parity, so the four neighbors never collide
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BX = 1'((b % 2));
    localparam logic BY = 1'((b / 2));
    logic [23:0]            mem [0:BANK_DEPTH-1];
    logic [8:0]             col, row;
    logic [BANK_ADDR_W-1:0] addr;
    logic                   we;

    assign col  = (in_samp.x1[0] == BX) ? {1'b0, in_samp.x1} : {1'b0, in_samp.x1} + 9'd1;
    assign row  = (in_samp.y1[0] == BY) ? {1'b0, in_samp.y1} : {1'b0, in_samp.y1} + 9'd1;
    assign addr = {row[7:1], col[7:1]};
    assign we   = in_valid && (in_samp.mode == MODE_LOAD) &&
                  (in_samp.x1[0] == BX) && (in_samp.y1[0] == BY);

    always_ff @(posedge clk) begin
      if (we) begin
        mem[addr] <= in_samp.pix;
      end
      rd[b] <= mem[addr];
    end
  end

  // blend weights
  assign wx1 = {1'b0, in_samp.fx};
  assign wy1 = {1'b0, in_samp.fy};
  assign wx0 = ONE_Q16 - wx1;
  assign wy0 = ONE_Q16 - wy1;

  // map banks back to the four corners
  always_comb begin
    case ({a_s.y1[0], a_s.x1[0]})
      2'b00: begin
        p[0] = rd[0]; p[1] = rd[1]; p[2] = rd[2]; p[3] = rd[3];
      end
      2'b01: begin
        p[0] = rd[1]; p[1] = rd[0]; p[2] = rd[3]; p[3] = rd[2];
      end
      2'b10: begin
        p[0] = rd[2]; p[1] = rd[3]; p[2] = rd[0]; p[3] = rd[1];
      end
      default: begin
        p[0] = rd[3]; p[1] = rd[2]; p[2] = rd[1]; p[3] = rd[0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v  <= 1'b0;
      b_v  <= 1'b0;
      done <= 1'b0;
    end else begin
      a_v  <= in_valid;
      b_v  <= a_v;
      done <= b_v && (b_s.mode == MODE_QUERY);
    end
  end

  // weight products, corner products, then the sum
  always_ff @(posedge clk) begin
    a_s    <= in_samp;
    a_w[0] <= {17'b0, wx0} * {17'b0, wy0};
    a_w[1] <= {17'b0, wx1} * {17'b0, wy0};
    a_w[2] <= {17'b0, wx0} * {17'b0, wy1};
    a_w[3] <= {17'b0, wx1} * {17'b0, wy1};

    b_s <= a_s;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 4; k++) begin
        b_pr[c][k] <= {8'b0, a_w[k]} * {34'b0, p[k][8*c +: 8]};
      end
    end
  end

  logic [43:0] acc [0:2];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = {2'b0, b_pr[c][0]} + {2'b0, b_pr[c][1]} +
               {2'b0, b_pr[c][2]} + {2'b0, b_pr[c][3]};
    end
  end

  always_ff @(posedge clk) begin
    out_ch0   <= b_s.zero ? 8'd0 : acc[0][39:32];
    out_ch1   <= b_s.zero ? 8'd0 : acc[1][39:32];
    out_ch2   <= b_s.zero ? 8'd0 : acc[2][39:32];
    in_window <= b_s.in_win;
  end

endmodule

`default_nettype wire
